// ===== sv/rrjs_pkg.sv =====
`default_nettype none

package rrjs_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ID_W = 8;
    localparam int BURST_W = 12;
    localparam int TIME_W = 16;
    localparam int QUANTUM_W = 8;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd4;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] left;
    } t_entry;

    typedef struct packed {
        logic push_a;
        logic push_p;
        logic pop;
    } t_qctl;

endpackage

`default_nettype wire

// ===== sv/rrjs_queue.sv =====
`default_nettype none

module rrjs_queue #(
    parameter int DEPTH = rrjs_pkg::QUEUE_DEPTH,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rrjs_pkg::t_qctl  i_ctl,
    input  rrjs_pkg::t_entry i_arr,
    input  rrjs_pkg::t_entry i_pre,
    output logic [CW-1:0]    o_count,
    output rrjs_pkg::t_entry o_head
);

    localparam int RW = ($clog2(DEPTH) > 1) ? $clog2(DEPTH) - 1 : 1;
    localparam int PW = RW + 1;
    localparam int ROWS = 1 << RW;

    rrjs_pkg::t_entry mem_even [ROWS];
    rrjs_pkg::t_entry mem_odd  [ROWS];

    logic [PW-1:0] r_head_ptr, n_head_ptr;
    logic [PW-1:0] r_tail_ptr, n_tail_ptr;
    logic [CW-1:0] r_count, n_count;

    logic [PW-1:0] wa, wp;
    logic [RW-1:0] rrow;
    logic          we_e, we_o;
    logic [RW-1:0] wrow_e, wrow_o;
    rrjs_pkg::t_entry wdat_e, wdat_o;

    rrjs_pkg::t_entry r_rd_e, r_rd_o;
    rrjs_pkg::t_entry r_byp_data, n_byp_data;
    logic r_byp, n_byp;
    logic r_bank;

    // The two pushes of one cycle land on consecutive slots, so they always
    // fall into different banks.
    assign wa = r_tail_ptr;
    assign wp = r_tail_ptr + PW'(i_ctl.push_a);
    assign n_head_ptr = r_head_ptr + PW'(i_ctl.pop);
    assign n_tail_ptr = r_tail_ptr + PW'(i_ctl.push_a) + PW'(i_ctl.push_p);
    assign n_count = r_count + CW'(i_ctl.push_a) + CW'(i_ctl.push_p) - CW'(i_ctl.pop);
    assign rrow = n_head_ptr[PW-1:1];

    always_comb begin
        we_e = 1'b0;
        wrow_e = wa[PW-1:1];
        wdat_e = i_arr;
        if (i_ctl.push_a && !wa[0]) begin
            we_e = 1'b1;
        end else if (i_ctl.push_p && !wp[0]) begin
            we_e = 1'b1;
            wrow_e = wp[PW-1:1];
            wdat_e = i_pre;
        end
    end

    always_comb begin
        we_o = 1'b0;
        wrow_o = wa[PW-1:1];
        wdat_o = i_arr;
        if (i_ctl.push_a && wa[0]) begin
            we_o = 1'b1;
        end else if (i_ctl.push_p && wp[0]) begin
            we_o = 1'b1;
            wrow_o = wp[PW-1:1];
            wdat_o = i_pre;
        end
    end

    // A slot written in the same cycle it is read as the new head is
    // forwarded from the write data.
    always_comb begin
        if (n_head_ptr[0]) begin
            n_byp = we_o && (wrow_o == rrow);
            n_byp_data = wdat_o;
        end else begin
            n_byp = we_e && (wrow_e == rrow);
            n_byp_data = wdat_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_e) begin
            mem_even[wrow_e] <= wdat_e;
        end
        r_rd_e <= mem_even[rrow];
    end

    always_ff @(posedge i_clk) begin
        if (we_o) begin
            mem_odd[wrow_o] <= wdat_o;
        end
        r_rd_o <= mem_odd[rrow];
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= n_byp_data;
        r_bank <= n_head_ptr[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_ptr <= '0;
            r_tail_ptr <= '0;
            r_count <= '0;
            r_byp <= 1'b0;
        end else begin
            r_head_ptr <= n_head_ptr;
            r_tail_ptr <= n_tail_ptr;
            r_count <= n_count;
            r_byp <= n_byp;
        end
    end

    assign o_count = r_count;
    assign o_head = r_byp ? r_byp_data : (r_bank ? r_rd_o : r_rd_e);

endmodule

`default_nettype wire

// ===== sv/round_robin_job_scheduler.sv =====
// Path: a tick item waits in the input register; a job that it completes is registered in
// the result register and shown on o_valid.
// Throughput: one tick item per cycle unless a held result stalls the input; the ready
// queue is a two-bank memory taking the arrival and the requeued job in the same cycle.
// Reset: synchronous, active low; clears time, CPU state, queue pointers, the
// overflow flag and sets the quantum to 4. Queue storage is not cleared.
`default_nettype none

module round_robin_job_scheduler #(
    parameter int DEPTH = rrjs_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_arrive_valid,
    input  logic [rrjs_pkg::ID_W-1:0]        i_job_id,
    input  logic [rrjs_pkg::BURST_W-1:0]     i_burst,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [rrjs_pkg::ID_W-1:0]        o_done_id,
    output logic [rrjs_pkg::TIME_W-1:0]      o_finish_time,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rrjs_pkg::QUANTUM_W-1:0]   i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = rrjs_pkg::TIME_W;
    localparam int BW = rrjs_pkg::BURST_W;

    logic                        r_in_valid;
    logic                        r_in_arr;
    rrjs_pkg::t_entry            r_in_entry;
    logic [rrjs_pkg::QUANTUM_W-1:0] r_quantum;

    logic                        r_busy, n_busy;
    logic [rrjs_pkg::ID_W-1:0]   r_run_id, n_run_id;
    logic [BW-1:0]               r_run_left, n_run_left;
    logic [TW-1:0]               r_slice_end, n_slice_end;
    logic [TW-1:0]               r_now;
    logic                        r_ovf, n_ovf;

    logic                        r_out_valid;
    logic [rrjs_pkg::ID_W-1:0]   r_out_id;
    logic [TW-1:0]               r_out_time;

    logic                        adv, in_acc;
    logic                        res;
    logic [TW-1:0]               res_time;
    rrjs_pkg::t_qctl             qctl;
    rrjs_pkg::t_entry            pre_entry, head_eff, entry;
    logic [CW-1:0]               q_count, cnt1;
    rrjs_pkg::t_entry            q_head;
    logic                        push_a, requeue, slice_hit, busy1, have;
    logic [BW-1:0]               q_eff;

    assign adv = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;
    assign in_acc = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign q_eff = (r_quantum == '0) ? BW'(1) : BW'(r_quantum);
    assign pre_entry = '{id: r_run_id, left: r_run_left};

    always_comb begin
        push_a = r_in_arr && (q_count != CW'(DEPTH));
        n_ovf = r_ovf || (r_in_arr && (q_count == CW'(DEPTH)));
        cnt1 = q_count + CW'(push_a);
        slice_hit = r_busy && (r_slice_end == r_now);
        busy1 = r_busy && !slice_hit;
        requeue = slice_hit && (r_run_left != '0);
        head_eff = (q_count == '0) ? r_in_entry : q_head;

        qctl = '0;
        have = 1'b0;
        entry = head_eff;
        qctl.push_a = push_a;
        if (!busy1) begin
            if (requeue) begin
                have = 1'b1;
                if (cnt1 == '0) begin
                    entry = pre_entry;
                end else begin
                    qctl.pop = 1'b1;
                    qctl.push_p = 1'b1;
                end
            end else if (cnt1 != '0) begin
                have = 1'b1;
                qctl.pop = 1'b1;
            end
        end

        n_busy = busy1;
        n_run_id = r_run_id;
        n_run_left = busy1 ? r_run_left : '0;
        n_slice_end = r_slice_end;
        res = 1'b0;
        res_time = r_now + TW'(entry.left);
        if (have) begin
            n_run_id = entry.id;
            if (entry.left > q_eff) begin
                n_run_left = entry.left - q_eff;
                n_slice_end = r_now + TW'(q_eff);
                n_busy = 1'b1;
            end else begin
                n_slice_end = res_time;
                n_busy = (entry.left != '0);
                res = 1'b1;
            end
        end

        if (!adv) begin
            qctl = '0;
        end
    end

    rrjs_queue #(
        .DEPTH(DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .i_arr   (r_in_entry),
        .i_pre   (pre_entry),
        .o_count (q_count),
        .o_head  (q_head)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_arr <= i_arrive_valid;
            r_in_entry <= '{id: i_job_id, left: i_burst};
        end
        if (adv && res) begin
            r_out_id <= entry.id;
            r_out_time <= res_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_quantum <= rrjs_pkg::QUANTUM_RESET;
            r_busy <= 1'b0;
            r_run_id <= '0;
            r_run_left <= '0;
            r_slice_end <= '0;
            r_now <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_in_valid <= in_acc || (r_in_valid && !adv);
            if (adv && res) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_quantum <= i_cfg_data;
            end
            if (adv) begin
                r_busy <= n_busy;
                r_run_id <= n_run_id;
                r_run_left <= n_run_left;
                r_slice_end <= n_slice_end;
                r_now <= r_now + TW'(1);
                r_ovf <= n_ovf;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_done_id = r_out_id;
    assign o_finish_time = r_out_time;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(DEPTH))
        else $error("ready queue count exceeds its depth");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared without reset");

    a_idle_no_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_run_left == '0))
        else $error("idle CPU holds a preempted job");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && res) |=> r_out_valid)
        else $error("completed job did not reach the result register");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
